// ===== hdl/cfp_pkg.sv =====
// Shared types and constants for the contour fingertip picker.
// No dependencies; imported by every module of the block.
package cfp_pkg;

    localparam int COORD_BITS   = 12;
    localparam int DIST_BITS    = 2 * COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int RUN_BITS     = 8;
    localparam int NUM_BITS     = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 32;
    localparam int DEF_MAX_TIPS  = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUN_LIMIT = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPACING   = 2'd3;

    localparam logic [RUN_BITS-1:0]   RUN_LIMIT_RST = 8'd40;
    localparam logic [COORD_BITS-1:0] SPACING_RST   = 12'd200;

    typedef struct packed {
        logic load;
        logic square;
        logic update;
    } cfp_cmd_t;

    typedef struct packed {
        logic tip_found;
    } cfp_status_t;

endpackage

// ===== hdl/contour_fingertip_picker.sv =====
// Top level of the contour fingertip picker: stream ports, config port,
// controller and datapath. Depends on cfp_pkg, cfp_ctrl, cfp_datapath.
//
//   channel   dir  handshake            payload
//   s_        in   s_tvalid/s_tready    s_tdata point_x,point_y; s_tuser contour_start
//   m_        out  m_tvalid/m_tready    m_tdata tip_x,tip_y,tip_number
//   cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each point passes through the steps accept, square (two 12x12 multipliers) and update.
// The update cycle waits only while a previous tip still sits in the output register.
// A new point is taken while a finished tip waits on m_.
// aresetn is synchronous; it clears the search state and loads register defaults.
module contour_fingertip_picker #(
    parameter int MAX_TIPS = cfp_pkg::DEF_MAX_TIPS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cfp_pkg::IN_DATA_BITS-1:0]   s_tdata,   // point_x, point_y
    input  logic                               s_tuser,   // contour_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cfp_pkg::OUT_DATA_BITS-1:0]  m_tdata,   // tip_x, tip_y, tip_number, zero pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cfp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [cfp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import cfp_pkg::*;

    cfp_cmd_t              cmd;
    cfp_status_t           status;
    logic [COORD_BITS-1:0] tip_x, tip_y;
    logic [NUM_BITS-1:0]   tip_number;

    assign cfg_ready = 1'b1;

    cfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cfp_datapath #(
        .MAX_TIPS (MAX_TIPS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .point_x       (s_tdata[COORD_BITS-1:0]),
        .point_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .contour_start (s_tuser),
        .cmd           (cmd),
        .status        (status),
        .tip_x         (tip_x),
        .tip_y         (tip_y),
        .tip_number    (tip_number)
    );

    assign m_tdata = {{(OUT_DATA_BITS - 2*COORD_BITS - NUM_BITS){1'b0}},
                      tip_number, tip_y, tip_x};

    a_load_then_square: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.square && !s_tready)
        else $error("square step did not follow a load");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.square || cmd.update) |-> !s_tready)
        else $error("input ready while a word is in flight");

    a_tip_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.update && status.tip_found))
        else $error("result word without a found tip");

    a_update_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_tvalid || m_tready))
        else $error("update while output word still held");

endmodule

// ===== hdl/cfp_ctrl.sv =====
// Controller for the fingertip picker: sequences load, square and update,
// and owns the stream handshakes. Depends on cfp_pkg.
module cfp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  cfp_pkg::cfp_status_t status,
    output cfp_pkg::cfp_cmd_t   cmd
);
    import cfp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SQUARE = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   advance;

    assign advance = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (advance) begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.update && status.tip_found) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ===== hdl/cfp_datapath.sv =====
// Datapath for the fingertip picker: config registers, distance squares,
// farthest-point tracking, run counter and the tip x store. Depends on cfp_pkg.
module cfp_datapath #(
    parameter int MAX_TIPS = cfp_pkg::DEF_MAX_TIPS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [cfp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [cfp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [cfp_pkg::COORD_BITS-1:0]     point_x,
    input  logic [cfp_pkg::COORD_BITS-1:0]     point_y,
    input  logic                               contour_start,
    input  cfp_pkg::cfp_cmd_t                  cmd,
    output cfp_pkg::cfp_status_t               status,
    output logic [cfp_pkg::COORD_BITS-1:0]     tip_x,
    output logic [cfp_pkg::COORD_BITS-1:0]     tip_y,
    output logic [cfp_pkg::NUM_BITS-1:0]       tip_number
);
    import cfp_pkg::*;

    localparam int TOT_W = $clog2(MAX_TIPS + 1);

    logic [COORD_BITS-1:0] center_x_reg, center_y_reg, spacing_reg;
    logic [RUN_BITS-1:0]   run_limit_reg;

    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  start_reg;
    logic [SQ_BITS-1:0]    sq_x_reg, sq_y_reg;

    logic [DIST_BITS-1:0]  best_dist_reg, best_dist_next;
    logic [COORD_BITS-1:0] best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic [RUN_BITS-1:0]   run_count_reg, run_count_next;
    logic [TOT_W-1:0]      tip_total_reg, tip_total_next;
    logic [COORD_BITS-1:0] tip_store [MAX_TIPS];

    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [NUM_BITS-1:0]   out_n_reg;

    logic [COORD_BITS-1:0] dx, dy;
    logic [DIST_BITS-1:0]  pt_dist, bd_eff;
    logic [RUN_BITS-1:0]   rc_eff;
    logic [TOT_W-1:0]      tt_eff;
    logic [COORD_BITS-1:0] bx_eff, by_eff;
    logic                  greater, equal, close_run, spaced, tip_found;
    logic [MAX_TIPS-1:0]   too_near;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            run_limit_reg <= RUN_LIMIT_RST;
            spacing_reg   <= SPACING_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER_X:  center_x_reg  <= cfg_data;
                CFG_CENTER_Y:  center_y_reg  <= cfg_data;
                CFG_RUN_LIMIT: run_limit_reg <= cfg_data[RUN_BITS-1:0];
                CFG_SPACING:   spacing_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input capture and squaring
    assign dx = (px_reg >= center_x_reg) ? px_reg - center_x_reg : center_x_reg - px_reg;
    assign dy = (py_reg >= center_y_reg) ? py_reg - center_y_reg : center_y_reg - py_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg    <= point_x;
            py_reg    <= point_y;
            start_reg <= contour_start;
        end
        if (cmd.square) begin
            sq_x_reg <= SQ_BITS'(dx) * SQ_BITS'(dx);
            sq_y_reg <= SQ_BITS'(dy) * SQ_BITS'(dy);
        end
    end

    // contour start clears the context ahead of the normal update
    always_comb begin
        bd_eff = start_reg ? '0     : best_dist_reg;
        rc_eff = start_reg ? '0     : run_count_reg;
        tt_eff = start_reg ? '0     : tip_total_reg;
        bx_eff = start_reg ? px_reg : best_x_reg;
        by_eff = start_reg ? py_reg : best_y_reg;
    end

    assign pt_dist   = DIST_BITS'(sq_x_reg) + DIST_BITS'(sq_y_reg);
    assign greater   = pt_dist > bd_eff;
    assign equal     = pt_dist == bd_eff;
    assign close_run = !greater && !equal && (rc_eff >= run_limit_reg);

    always_comb begin
        logic [COORD_BITS-1:0] sep;
        for (int k = 0; k < MAX_TIPS; k++) begin
            sep = (bx_eff >= tip_store[k]) ? bx_eff - tip_store[k] : tip_store[k] - bx_eff;
            too_near[k] = (TOT_W'(k) < tt_eff) && (sep < spacing_reg);
        end
    end

    assign spaced    = ~|too_near;
    assign tip_found = close_run && !(by_eff > center_y_reg) && spaced
                       && (tt_eff < TOT_W'(MAX_TIPS));
    assign status.tip_found = tip_found;

    always_comb begin
        best_dist_next = bd_eff;
        best_x_next    = bx_eff;
        best_y_next    = by_eff;
        run_count_next = rc_eff;
        tip_total_next = tt_eff;
        priority if (greater) begin
            best_dist_next = pt_dist;
            best_x_next    = px_reg;
            best_y_next    = py_reg;
        end else if (equal) begin
            best_dist_next = bd_eff;
        end else if (!close_run) begin
            run_count_next = rc_eff + RUN_BITS'(1);
        end else begin
            run_count_next = '0;
            best_dist_next = '0;
            if (tip_found) begin
                tip_total_next = tt_eff + TOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            run_count_reg <= '0;
            tip_total_reg <= '0;
        end else if (cmd.update) begin
            best_dist_reg <= best_dist_next;
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            run_count_reg <= run_count_next;
            tip_total_reg <= tip_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_TIPS; k++) begin
            if (cmd.update && tip_found && (tt_eff == TOT_W'(k))) begin
                tip_store[k] <= bx_eff;
            end
        end
        if (cmd.update && tip_found) begin
            out_x_reg <= bx_eff;
            out_y_reg <= by_eff;
            out_n_reg <= NUM_BITS'(tt_eff);
        end
    end

    assign tip_x      = out_x_reg;
    assign tip_y      = out_y_reg;
    assign tip_number = out_n_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for contour_fingertip_picker: contour points in, fingertips out.
// Depends on cfp_pkg and the RTL of the block; predicts every tip and compares word by word.
module testbench;
    import cfp_pkg::*;

    localparam int MAX_TIPS       = DEF_MAX_TIPS;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [COORD_BITS-1:0] tip_x;
        logic [COORD_BITS-1:0] tip_y;
        logic [NUM_BITS-1:0]   tip_num;
    } tip_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata   = '0;    // point_x, point_y
    logic                     s_tuser   = 1'b0;  // contour_start
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;           // tip_x, tip_y, tip_number, zero pad
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // predictor copy of configuration and search state
    logic [COORD_BITS-1:0] ctr_x   = '0;
    logic [COORD_BITS-1:0] ctr_y   = '0;
    logic [RUN_BITS-1:0]   run_lim = RUN_LIMIT_RST;
    logic [COORD_BITS-1:0] min_gap = SPACING_RST;
    logic [DIST_BITS-1:0]  far_dist = '0;
    logic [COORD_BITS-1:0] far_x    = '0;
    logic [COORD_BITS-1:0] far_y    = '0;
    logic [RUN_BITS-1:0]   run_cnt  = '0;
    int                    tip_cnt  = 0;
    logic [COORD_BITS-1:0] tip_xs [MAX_TIPS];

    tip_t tips_due [$];
    int   errors      = 0;
    int   points_sent = 0;
    int   quiet       = 0;
    int   stall_left  = 0;
    bit   send_idle   = 1'b1;
    bit   recv_idle   = 1'b1;

    contour_fingertip_picker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'hFFF;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic void track_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                                        logic start);
        int   dx;
        int   dy;
        int   gap;
        int   pt_dist;
        bit   spaced;
        tip_t t;
        if (start) begin
            far_dist = '0;
            run_cnt  = '0;
            tip_cnt  = 0;
            far_x    = px;
            far_y    = py;
        end
        dx      = int'(px) - int'(ctr_x);
        dy      = int'(py) - int'(ctr_y);
        pt_dist = dx * dx + dy * dy;
        if (pt_dist > int'(far_dist)) begin
            far_dist = pt_dist[DIST_BITS-1:0];
            far_x    = px;
            far_y    = py;
            return;
        end
        if (pt_dist == int'(far_dist)) return;
        if (run_cnt < run_lim) begin
            run_cnt++;
            return;
        end
        run_cnt  = '0;
        far_dist = '0;
        if (far_y > ctr_y) return;
        spaced = 1'b1;
        for (int k = 0; k < tip_cnt; k++) begin
            gap = int'(far_x) - int'(tip_xs[k]);
            if (gap < 0) gap = -gap;
            if (gap < int'(min_gap)) spaced = 1'b0;
        end
        if (!spaced || tip_cnt >= MAX_TIPS) return;
        tip_xs[tip_cnt] = far_x;
        t.tip_x   = far_x;
        t.tip_y   = far_y;
        t.tip_num = tip_cnt[NUM_BITS-1:0];
        tips_due  = {tips_due, t};
        tip_cnt++;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    task automatic check_tip(logic [OUT_DATA_BITS-1:0] word);
        tip_t want;
        if (tips_due.size() == 0) begin
            report_mismatch("unexpected tip word", int'(word), 0);
            return;
        end
        want = tips_due.pop_front();
        if (word[11:0] != want.tip_x)
            report_mismatch("tip_x", int'(word[11:0]), int'(want.tip_x));
        if (word[23:12] != want.tip_y)
            report_mismatch("tip_y", int'(word[23:12]), int'(want.tip_y));
        if (word[26:24] != want.tip_num)
            report_mismatch("tip_number", int'(word[26:24]), int'(want.tip_num));
        if (word[31:27] != '0) report_mismatch("pad", int'(word[31:27]), 0);
    endtask

    // result side: check and random stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_tip(m_tdata);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (recv_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", quiet);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py, logic start);
        if (send_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        track_point(px, py, start);
        points_sent++;
    endtask

    // stop sending, wait for every predicted tip, then let the pipeline empty
    task automatic settle_outputs();
        s_tvalid <= 1'b0;
        while (tips_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(int cx, int cy, int rl, int sp);
        logic [CFG_DATA_BITS-1:0] vals [4];
        logic [CFG_IDX_BITS-1:0]  idxs [4];
        settle_outputs();
        idxs = '{CFG_CENTER_X, CFG_CENTER_Y, CFG_RUN_LIMIT, CFG_SPACING};
        vals = '{cx[11:0], cy[11:0], {4'd0, rl[7:0]}, sp[11:0]};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        ctr_x   = cx[11:0];
        ctr_y   = cy[11:0];
        run_lim = rl[7:0];
        min_gap = sp[11:0];
    endtask

    // one contour: rise toward each finger peak, then a run of closer points
    task automatic run_contour(int fingers);
        int px;
        int py;
        int steps;
        int tail;
        int r;
        logic [COORD_BITS-1:0] lx;
        logic [COORD_BITS-1:0] ly;
        lx = clamp_coord(ctr_x + $urandom_range(0, 60) - 30);
        ly = clamp_coord(ctr_y + $urandom_range(0, 60) - 30);
        send_point(lx, ly, 1'b1);
        for (int f = 0; f < fingers; f++) begin
            px = int'(clamp_coord(int'(ctr_x) + int'($urandom_range(0, 3000)) - 1500));
            if ($urandom_range(0, 6) == 0)
                py = int'(clamp_coord(int'(ctr_y) + int'($urandom_range(1, 1500))));
            else
                py = int'(clamp_coord(int'(ctr_y) - int'($urandom_range(0, 1500))));
            steps = $urandom_range(1, 4);
            for (int k = 1; k <= steps; k++) begin
                lx = clamp_coord(int'(ctr_x) + (px - int'(ctr_x)) * k / steps);
                ly = clamp_coord(int'(ctr_y) + (py - int'(ctr_y)) * k / steps);
                send_point(lx, ly, 1'b0);
            end
            tail = int'(run_lim) + 1 + $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) tail = $urandom_range(0, run_lim);
            for (int j = 0; j < tail; j++) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    lx = 12'($urandom_range(0, 4095));
                    ly = 12'($urandom_range(0, 4095));
                end else if (r != 1) begin
                    lx = clamp_coord(int'(ctr_x) + int'($urandom_range(0, 40)) - 20);
                    ly = clamp_coord(int'(ctr_y) + int'($urandom_range(0, 40)) - 20);
                end
                send_point(lx, ly, 1'b0);
            end
        end
    endtask

    // finger count is trimmed so long runs do not overshoot the point budget
    task automatic test_contours(int count);
        int target;
        int fingers;
        target = points_sent + count;
        while (points_sent < target) begin
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            fingers = $urandom_range(1, 10);
            if (fingers * (int'(run_lim) + 4) > target - points_sent)
                fingers = (target - points_sent) / (int'(run_lim) + 4) + 1;
            run_contour(fingers);
        end
    endtask

    task automatic test_directed();
        configure(2048, 2048, 0, 200);
        send_point(12'd2048, 12'd2048, 1'b1);  // start on the centre
        send_point(12'd4095, 12'd0, 1'b0);
        send_point(12'd4095, 12'd0, 1'b0);     // equal distance
        send_point(12'd2048, 12'd2048, 1'b0);  // run close, first tip
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd2048, 12'd2048, 1'b0);  // second tip
        send_point(12'd100, 12'd0, 1'b0);
        send_point(12'd2048, 12'd2048, 1'b0);  // too close to earlier tip
        send_point(12'd2000, 12'd4095, 1'b0);
        send_point(12'd2048, 12'd2048, 1'b0);  // below centre
        send_point(12'd0, 12'd4095, 1'b1);
        send_point(12'd2048, 12'd2048, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b1);
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd2048, 12'd2047, 1'b0);
        send_point(12'd2048, 12'd2048, 1'b0);
    endtask

    task automatic test_full_store();
        configure(2048, 2048, 0, 0);
        send_point(12'd2048, 12'd2048, 1'b1);
        for (int f = 0; f < 12; f++) begin
            send_point(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 2047)), 1'b0);
            send_point(12'd2048, 12'd2048, 1'b0);
        end
    endtask

    task automatic test_noise(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                send_idle = $urandom_range(0, 1) != 0;
                recv_idle = $urandom_range(0, 1) != 0;
            end
            send_point(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       $urandom_range(0, 31) == 0);
        end
    endtask

    task automatic test_pressure();
        configure(2048, 3000, 2, 150);
        run_contour(6);
        settle_outputs();
        run_contour(6);
        test_contours(150);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_store();
        configure(2048, 2048, 3, 200);
        test_contours(400);
        configure(1000, 3000, 0, 50);
        test_contours(250);
        configure(4095, 4095, 10, 4095);
        test_contours(200);
        configure(0, 0, 255, 0);
        test_contours(250);
        configure(2048, 1024, 1, 100);
        test_noise(250);
        test_pressure();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        configure(3000, 2500, 2, 300);
        test_contours(300);
        settle_outputs();
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cfp_pkg.sv
hdl/cfp_ctrl.sv
hdl/cfp_datapath.sv
hdl/contour_fingertip_picker.sv
tb/testbench.sv
